// ===== hw/rtl/urc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types and constants for the ultrasonic range controller.
// ----------------------------------------------------------------------------
package urc_pkg;

    // flight counter width default
    localparam int COUNT_BITS_DEF = 16;

    // field widths
    localparam int DIST_W    = 11;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int HALF_W    = 8;
    localparam int PULSE_W   = 4;
    localparam int PHASE_W   = 16;
    localparam int EDGE_W    = 5;

    // distance scale: cm = count * SPEED_NUM / SPEED_DEN
    localparam int SPEED_NUM = 173;
    localparam int SPEED_DEN = 10000;
    localparam int REM_W     = 14;
    localparam int DIST_SAT  = 2047;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANKING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd12750;
    localparam logic [HALF_W-1:0]  HALF_RST     = 8'd12;
    localparam logic [PULSE_W-1:0] BURST_RST    = 4'd6;
    localparam logic [CFG_W-1:0]   BLANKING_RST = 16'd200;
    localparam logic [CFG_W-1:0]   LIMIT_RST    = 16'hFFFF;

    typedef struct packed {
        logic [CFG_W-1:0]   debounce_ticks;
        logic [HALF_W-1:0]  half_period_ticks;
        logic [PULSE_W-1:0] burst_pulses;
        logic [CFG_W-1:0]   blanking_ticks;
        logic [CFG_W-1:0]   count_limit;
    } cfg_t;

    typedef struct packed {
        logic start_level;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic               drive_level;
        logic               busy_res;
        logic               done_pulse;
        logic               no_echo;
        logic [DIST_W-1:0]  distance_cm;
        logic [DIGIT_W-1:0] digit_ones;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_thousands;
    } out_item_t;

endpackage

// ===== hw/rtl/urc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_in_stage
// Input register: holds one tick request until the core takes it.
// ----------------------------------------------------------------------------
module urc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  urc_pkg::in_item_t in_item,
    output logic              stage_valid,
    input  logic              stage_take,
    output urc_pkg::in_item_t stage_item
);
    import urc_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // room when empty or when the held request leaves this cycle
    assign in_ready    = !valid_reg || stage_take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== hw/rtl/urc_dist_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_dist_acc
// Running distance: tracks count*173/10000 and its decimal digits as the
// flight counter advances, one add and compare per tick.
// ----------------------------------------------------------------------------
module urc_dist_acc (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   clear,
    input  logic                                   advance,
    output logic [urc_pkg::DIST_W-1:0]             dist_cm,
    output logic [urc_pkg::DIGITS*urc_pkg::DIGIT_W-1:0] digits
);
    import urc_pkg::*;

    localparam logic [REM_W-1:0]  NUM_STEP = REM_W'(SPEED_NUM);
    localparam logic [REM_W-1:0]  DEN      = REM_W'(SPEED_DEN);
    localparam logic [DIST_W-1:0] SAT      = DIST_W'(DIST_SAT);

    logic [REM_W-1:0]            rem_reg,   rem_next;
    logic [DIST_W-1:0]           quo_reg,   quo_next;
    logic [DIGITS*DIGIT_W-1:0]   bcd_reg,   bcd_next;
    logic [REM_W-1:0]            rem_sum;
    logic [DIGITS*DIGIT_W-1:0]   bcd_inc;
    logic                        carry;
    logic [DIGIT_W-1:0]          dig;

    // decimal increment with ripple carry
    always_comb
    begin
        carry   = 1'b1;
        bcd_inc = bcd_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = bcd_reg[i*DIGIT_W +: DIGIT_W];
            if (carry)
            begin
                if (dig == DIGIT_W'(9))
                begin
                    bcd_inc[i*DIGIT_W +: DIGIT_W] = '0;
                end
                else
                begin
                    bcd_inc[i*DIGIT_W +: DIGIT_W] = dig + DIGIT_W'(1);
                    carry = 1'b0;
                end
            end
        end
    end

    // remainder step, quotient bumps when remainder passes the divisor
    always_comb
    begin
        rem_sum  = rem_reg + NUM_STEP;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bcd_next = bcd_reg;
        if (clear)
        begin
            rem_next = '0;
            quo_next = '0;
            bcd_next = '0;
        end
        else if (advance)
        begin
            if (rem_sum >= DEN)
            begin
                rem_next = rem_sum - DEN;
                if (quo_reg != SAT)
                begin
                    quo_next = quo_reg + DIST_W'(1);
                    bcd_next = bcd_inc;
                end
            end
            else
            begin
                rem_next = rem_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            bcd_reg <= bcd_next;
        end
    end

    assign dist_cm = quo_reg;
    assign digits  = bcd_reg;

endmodule

// ===== hw/rtl/urc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_core
// Measurement sequencer: debounce, transmit burst, blanking, listening,
// with the flight counter and the held result.
// ----------------------------------------------------------------------------
module urc_core #(
    parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  urc_pkg::cfg_t      cfg,
    input  logic               step,
    input  urc_pkg::in_item_t  item,
    output urc_pkg::out_item_t result
);
    import urc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] FC_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DEBOUNCE = 5'b00010,
        PH_BURST    = 5'b00100,
        PH_BLANK    = 5'b01000,
        PH_LISTEN   = 5'b10000
    } phase_t;

    phase_t                       phase_reg,    phase_next;
    logic [COUNT_BITS-1:0]        flight_reg,   flight_next;
    logic [PHASE_W-1:0]           pcount_reg,   pcount_next;
    logic [EDGE_W-1:0]            edge_reg,     edge_next;
    logic                         drive_reg,    drive_next;
    logic                         timeout_reg,  timeout_next;
    logic [DIST_W-1:0]            dist_reg,     dist_next;
    logic [DIGITS*DIGIT_W-1:0]    digits_reg,   digits_next;

    logic                         start_low;
    logic                         echo_low;
    logic                         done;
    logic                         acc_clear;
    logic                         acc_adv;
    logic [DIST_W-1:0]            acc_dist;
    logic [DIGITS*DIGIT_W-1:0]    acc_digits;
    logic [COUNT_BITS-1:0]        fc_inc;
    logic                         fc_sat;
    logic                         limit_hit;
    logic [PHASE_W-1:0]           pc_inc;
    logic [EDGE_W-1:0]            edge_inc;

    assign start_low = !item.start_level;
    assign echo_low  = !item.echo_level;

    // flight counter, saturating, and limit check
    assign fc_sat    = (flight_reg == FC_MAX);
    assign fc_inc    = fc_sat ? flight_reg : flight_reg + COUNT_BITS'(1);
    assign limit_hit = (CMP_W'(fc_inc) >= CMP_W'(cfg.count_limit)) || (fc_inc == FC_MAX);
    assign pc_inc    = pcount_reg + PHASE_W'(1);
    assign edge_inc  = edge_reg + EDGE_W'(1);

    urc_dist_acc u_dist_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (step && acc_clear),
        .advance (step && acc_adv),
        .dist_cm (acc_dist),
        .digits  (acc_digits)
    );

    // next state for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        flight_next  = flight_reg;
        pcount_next  = pcount_reg;
        edge_next    = edge_reg;
        drive_next   = drive_reg;
        timeout_next = timeout_reg;
        dist_next    = dist_reg;
        digits_next  = digits_reg;
        done         = 1'b0;
        acc_clear    = 1'b0;
        acc_adv      = 1'b0;
        unique case (phase_reg) inside
            PH_DEBOUNCE:
            begin
                pcount_next = pc_inc;
                if (pc_inc >= cfg.debounce_ticks || pc_inc == '0)
                begin
                    if (start_low)
                    begin
                        phase_next   = PH_BURST;
                        flight_next  = '0;
                        pcount_next  = '0;
                        edge_next    = '0;
                        drive_next   = 1'b0;
                        dist_next    = '0;
                        digits_next  = '0;
                        timeout_next = 1'b0;
                        acc_clear    = 1'b1;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        pcount_next = '0;
                    end
                end
            end
            PH_BURST, PH_BLANK, PH_LISTEN:
            begin
                if (phase_reg == PH_LISTEN && echo_low)
                begin
                    // echo wins over the limit, count before increment
                    dist_next    = acc_dist;
                    digits_next  = acc_digits;
                    timeout_next = 1'b0;
                    phase_next   = PH_IDLE;
                    pcount_next  = '0;
                    edge_next    = '0;
                    drive_next   = 1'b1;
                    done         = 1'b1;
                end
                else
                begin
                    flight_next = fc_inc;
                    acc_adv     = !fc_sat;
                    if (limit_hit)
                    begin
                        dist_next    = '0;
                        digits_next  = '0;
                        timeout_next = 1'b1;
                        phase_next   = PH_IDLE;
                        pcount_next  = '0;
                        edge_next    = '0;
                        drive_next   = 1'b1;
                        done         = 1'b1;
                    end
                    else if (phase_reg == PH_BURST)
                    begin
                        // half period elapsed: toggle the drive
                        pcount_next = pc_inc;
                        if (pc_inc >= PHASE_W'(cfg.half_period_ticks))
                        begin
                            pcount_next = '0;
                            edge_next   = edge_inc;
                            drive_next  = !drive_reg;
                            if (edge_inc >= {cfg.burst_pulses, 1'b0})
                            begin
                                drive_next = 1'b1;
                                phase_next = PH_BLANK;
                            end
                        end
                    end
                    else if (phase_reg == PH_BLANK)
                    begin
                        if (pcount_reg >= cfg.blanking_ticks || pc_inc >= cfg.blanking_ticks)
                        begin
                            phase_next  = PH_LISTEN;
                            pcount_next = '0;
                        end
                        else
                        begin
                            pcount_next = pc_inc;
                        end
                    end
                end
            end
            default:
            begin
                // idle, and any stray code behaves as idle
                phase_next = PH_IDLE;
                if (start_low)
                begin
                    phase_next  = PH_DEBOUNCE;
                    pcount_next = '0;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            flight_reg  <= '0;
            pcount_reg  <= '0;
            edge_reg    <= '0;
            drive_reg   <= 1'b1;
            timeout_reg <= 1'b0;
            dist_reg    <= '0;
            digits_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            flight_reg  <= flight_next;
            pcount_reg  <= pcount_next;
            edge_reg    <= edge_next;
            drive_reg   <= drive_next;
            timeout_reg <= timeout_next;
            dist_reg    <= dist_next;
            digits_reg  <= digits_next;
        end
    end

    // result of this tick, taken from the updated state
    always_comb
    begin
        result.drive_level     = drive_next;
        result.busy_res        = (phase_next == PH_BURST) || (phase_next == PH_BLANK)
                                 || (phase_next == PH_LISTEN);
        result.done_pulse      = done;
        result.no_echo         = timeout_next;
        result.distance_cm     = dist_next;
        result.digit_ones      = digits_next[0*DIGIT_W +: DIGIT_W];
        result.digit_tens      = digits_next[1*DIGIT_W +: DIGIT_W];
        result.digit_hundreds  = digits_next[2*DIGIT_W +: DIGIT_W];
        result.digit_thousands = digits_next[3*DIGIT_W +: DIGIT_W];
    end

endmodule

// ===== hw/rtl/urc_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_out_queue
// Two-entry result buffer: output register plus skid register, so a new
// result can enter while the current one waits to be taken.
// ----------------------------------------------------------------------------
module urc_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  urc_pkg::out_item_t push_item,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output urc_pkg::out_item_t out_item
);
    import urc_pkg::*;

    logic      head_valid_reg;
    logic      skid_valid_reg;
    out_item_t head_reg;
    out_item_t skid_reg;
    logic      head_free;

    assign room      = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;
    assign head_free = !head_valid_reg || out_ready;

    // occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload movement
    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_item;
                end
            end
            else if (push)
            begin
                head_reg <= push_item;
            end
        end
        else if (push)
        begin
            skid_reg <= push_item;
        end
    end

endmodule

// ===== hw/rtl/ultrasonic_range_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_controller
// Ultrasonic time-of-flight range finder: one request per time-base tick,
// one result per tick with drive level, status and distance digits.
//
//   channel   direction  signals                       carries
//   in        input      in_valid / in_ready           start and echo levels
//   out       output     out_valid / out_ready         drive, status, distance
//   cfg       input      cfg_wr_en, cfg_index, cfg_data timing registers
//
// One request per cycle while in_ready is high; each request is held in the
// input register, then the state update writes its result into the result
// buffer, from which it can be taken.
// Distance is kept as a running quotient and decimal count beside the flight
// counter, so the echo tick only copies it.
// Reset loads the register defaults and returns the sequencer to idle.
// in_ready drops only when the two-entry result buffer is full.
// ----------------------------------------------------------------------------
module ultrasonic_range_controller #(
    parameter int COUNT_BITS = urc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  urc_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output urc_pkg::out_item_t                out_item,
    input  logic                              cfg_wr_en,
    input  logic [urc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [urc_pkg::CFG_W-1:0]         cfg_data
);
    import urc_pkg::*;

    cfg_t      cfg_reg;
    logic      stage_valid;
    in_item_t  stage_item;
    logic      room;
    logic      take;
    out_item_t result;

    assign take = stage_valid && room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RST;
            cfg_reg.half_period_ticks <= HALF_RST;
            cfg_reg.burst_pulses      <= BURST_RST;
            cfg_reg.blanking_ticks    <= BLANKING_RST;
            cfg_reg.count_limit       <= LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:    cfg_reg.debounce_ticks    <= cfg_data;
                CFG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data[HALF_W-1:0];
                CFG_BURST:       cfg_reg.burst_pulses      <= cfg_data[PULSE_W-1:0];
                CFG_BLANKING:    cfg_reg.blanking_ticks    <= cfg_data;
                CFG_LIMIT:       cfg_reg.count_limit       <= cfg_data;
                default:         ;
            endcase
        end
    end

    urc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .stage_valid (stage_valid),
        .stage_take  (take),
        .stage_item  (stage_item)
    );

    urc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .step   (take),
        .item   (stage_item),
        .result (result)
    );

    urc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_item (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== sim/tb_ultrasonic_range_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_controller
// Self-checking bench for the ultrasonic range controller. Each tick request
// runs through a local model of the ranging sequencer (debounce, burst,
// blanking, listening). The expected reading goes into a queue, and every
// returned reading is compared field by field. Directed tests cover zero
// and maximum timing settings and each timeout path. Random tests then run
// state-aware start and echo patterns under changing timing settings.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_controller;

    import urc_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int unsigned FLIGHT_MAX = (1 << COUNT_BITS) - 1;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DEBOUNCE,
        SEQ_BURST,
        SEQ_BLANK,
        SEQ_LISTEN
    } seq_phase_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // local copy of the timing registers and sequencer state
    cfg_t              timing = cfg_t'{DEBOUNCE_RST, HALF_RST, BURST_RST, BLANKING_RST,
                                       LIMIT_RST};
    seq_phase_t        seq_phase    = SEQ_IDLE;
    int unsigned       flight_ticks = 0;
    int unsigned       hold_ticks   = 0;
    int unsigned       edge_ticks   = 0;
    logic              drive_lvl    = 1'b1;
    logic [DIST_W-1:0] dist_cm      = '0;
    logic              no_echo_flag = 1'b0;

    out_item_t   expected_readings[$];
    out_item_t   got_reading;
    out_item_t   want_reading;
    int unsigned error_count = 0;
    int unsigned result_no   = 0;

    // idle windows shared by both sides
    logic        quiet_span  = 1'b0;
    int unsigned span_cycles = 0;

    ultrasonic_range_controller #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("timeout: readings still outstanding");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one tick of the ranging sequencer, returns the reading after the update
    function automatic out_item_t range_step(in_item_t req);
        out_item_t       res;
        logic            start_low;
        logic            echo_low;
        logic            ended;
        int unsigned     lim;
        longint unsigned scaled;
        start_low = !req.start_level;
        echo_low  = !req.echo_level;
        ended     = 1'b0;
        case (seq_phase) inside
            SEQ_DEBOUNCE:
            begin
                hold_ticks = (hold_ticks + 1) & 16'hFFFF;
                if (hold_ticks >= timing.debounce_ticks || hold_ticks == 0)
                begin
                    if (start_low)
                    begin
                        seq_phase    = SEQ_BURST;
                        flight_ticks = 0;
                        hold_ticks   = 0;
                        edge_ticks   = 0;
                        drive_lvl    = 1'b0;
                        dist_cm      = '0;
                        no_echo_flag = 1'b0;
                    end
                    else
                    begin
                        seq_phase  = SEQ_IDLE;
                        hold_ticks = 0;
                    end
                end
            end
            SEQ_BURST, SEQ_BLANK, SEQ_LISTEN:
            begin
                if (seq_phase == SEQ_LISTEN && echo_low)
                begin
                    // echo wins over the limit, using the count before this tick
                    scaled = longint'(flight_ticks) * SPEED_NUM / SPEED_DEN;
                    dist_cm = (scaled > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(scaled);
                    no_echo_flag = 1'b0;
                    ended = 1'b1;
                end
                else
                begin
                    lim = (timing.count_limit < FLIGHT_MAX) ? timing.count_limit : FLIGHT_MAX;
                    if (flight_ticks < FLIGHT_MAX)
                        flight_ticks = flight_ticks + 1;
                    if (flight_ticks >= lim)
                    begin
                        dist_cm      = '0;
                        no_echo_flag = 1'b1;
                        ended        = 1'b1;
                    end
                    else if (seq_phase == SEQ_BURST)
                    begin
                        hold_ticks = hold_ticks + 1;
                        if (hold_ticks >= timing.half_period_ticks)
                        begin
                            hold_ticks = 0;
                            edge_ticks = (edge_ticks + 1) & 5'h1F;
                            drive_lvl  = !drive_lvl;
                            if (edge_ticks >= 2 * int'(timing.burst_pulses))
                            begin
                                drive_lvl = 1'b1;
                                seq_phase = SEQ_BLANK;
                            end
                        end
                    end
                    else if (seq_phase == SEQ_BLANK)
                    begin
                        if (hold_ticks < timing.blanking_ticks)
                            hold_ticks = hold_ticks + 1;
                        if (hold_ticks >= timing.blanking_ticks)
                        begin
                            seq_phase  = SEQ_LISTEN;
                            hold_ticks = 0;
                        end
                    end
                end
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                if (start_low)
                begin
                    seq_phase  = SEQ_DEBOUNCE;
                    hold_ticks = 0;
                end
            end
        endcase
        // measurement over: back to idle with the drive released
        if (ended)
        begin
            seq_phase  = SEQ_IDLE;
            hold_ticks = 0;
            edge_ticks = 0;
            drive_lvl  = 1'b1;
        end
        res.drive_level     = drive_lvl;
        res.busy_res        = seq_phase inside {SEQ_BURST, SEQ_BLANK, SEQ_LISTEN};
        res.done_pulse      = ended;
        res.no_echo         = no_echo_flag;
        res.distance_cm     = dist_cm;
        res.digit_ones      = DIGIT_W'(dist_cm % 10);
        res.digit_tens      = DIGIT_W'((dist_cm / 10) % 10);
        res.digit_hundreds  = DIGIT_W'((dist_cm / 100) % 10);
        res.digit_thousands = DIGIT_W'((dist_cm / 1000) % 10);
        return res;
    endfunction

    task automatic note_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            note_mismatch($sformatf("reading %0d %s got %0d expected %0d",
                                    result_no, name, got, want));
    endtask

    // quiet windows and receiver stalls
    always @(posedge clk)
    begin
        span_cycles <= span_cycles + 1;
        if (span_cycles % 500 == 0)
            quiet_span <= ($urandom_range(3) == 0);
        out_ready <= quiet_span || ($urandom_range(99) >= 7);
    end

    // compare each returned reading with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_reading = out_item;
            if (expected_readings.size() == 0)
            begin
                note_mismatch($sformatf("reading %0d arrived with no request outstanding",
                                        result_no));
            end
            else
            begin
                want_reading = expected_readings.pop_front();
                check_field("drive_level", got_reading.drive_level, want_reading.drive_level);
                check_field("busy_res", got_reading.busy_res, want_reading.busy_res);
                check_field("done_pulse", got_reading.done_pulse, want_reading.done_pulse);
                check_field("no_echo", got_reading.no_echo, want_reading.no_echo);
                check_field("distance_cm", got_reading.distance_cm, want_reading.distance_cm);
                check_field("digit_ones", got_reading.digit_ones, want_reading.digit_ones);
                check_field("digit_tens", got_reading.digit_tens, want_reading.digit_tens);
                check_field("digit_hundreds", got_reading.digit_hundreds,
                            want_reading.digit_hundreds);
                check_field("digit_thousands", got_reading.digit_thousands,
                            want_reading.digit_thousands);
            end
            result_no++;
        end
    end

    // send one request and predict its reading once it is taken
    task automatic send_tick(input logic start_lvl, input logic echo_lvl);
        in_item_t req;
        req.start_level = start_lvl;
        req.echo_level  = echo_lvl;
        while (!quiet_span && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_readings.push_back(range_step(req));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // write all timing registers once the block has gone quiet
    task automatic program_timing(input cfg_t s);
        logic [CFG_W-1:0] junk;
        drain_results();
        junk = CFG_W'($urandom());
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= s.debounce_ticks;
        @(posedge clk);
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= {junk[CFG_W-1:HALF_W], s.half_period_ticks};
        @(posedge clk);
        cfg_index <= CFG_BURST;
        cfg_data  <= {junk[CFG_W-1:PULSE_W], s.burst_pulses};
        @(posedge clk);
        cfg_index <= CFG_BLANKING;
        cfg_data  <= s.blanking_ticks;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= s.count_limit;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        timing = s;
    endtask

    // hold start until a burst begins
    task automatic press_start();
        while (seq_phase != SEQ_BURST)
            send_tick(1'b0, 1'b1);
    endtask

    // let the measurement run out with the start released
    task automatic ride_out(input logic echo_lvl);
        while (seq_phase != SEQ_IDLE)
            send_tick(1'b1, echo_lvl);
    endtask

    // register defaults: idle ticks, then a press that stays in debounce
    task automatic test_reset_values();
        repeat (3) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
    endtask

    // zero debounce, half period, pulses, blanking and limit
    task automatic test_zero_settings();
        program_timing(cfg_t'{16'd0, 8'd0, 4'd0, 16'd0, 16'd0});
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        program_timing(cfg_t'{16'd0, 8'd0, 4'd0, 16'd0, 16'd10});
        press_start();
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // release during debounce, then echo ignored in burst and blanking
    task automatic test_debounce_release();
        program_timing(cfg_t'{16'd3, 8'd2, 4'd2, 16'd3, 16'd200});
        send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b1, 1'b1);
        repeat (4) send_tick(1'b0, 1'b1);
        while (seq_phase == SEQ_BURST)
            send_tick(1'b1, 1'b0);
        while (seq_phase == SEQ_BLANK)
            send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b1, 1'b1);
    endtask

    // no-echo endings in burst, blanking and listening, and echo on the limit tick
    task automatic test_timeouts();
        program_timing(cfg_t'{16'd1, 8'd10, 4'd15, 16'd5, 16'd40});
        press_start();
        ride_out(1'b1);
        program_timing(cfg_t'{16'd1, 8'd1, 4'd2, 16'd50, 16'd20});
        press_start();
        ride_out(1'b0);
        program_timing(cfg_t'{16'd1, 8'd1, 4'd1, 16'd2, 16'd30});
        press_start();
        ride_out(1'b1);
        program_timing(cfg_t'{16'd1, 8'd1, 4'd1, 16'd0, 16'd30});
        press_start();
        while (seq_phase != SEQ_IDLE && !(seq_phase == SEQ_LISTEN && flight_ticks >= 29))
            send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
    endtask

    // maximum half period and pulses ending in the burst, then maximum
    // blanking ending in the blanking window
    task automatic test_slow_corners();
        program_timing(cfg_t'{16'd1, 8'hFF, 4'hF, 16'hFFFF, 16'd260});
        press_start();
        ride_out(1'b1);
        program_timing(cfg_t'{16'd1, 8'd1, 4'hF, 16'hFFFF, 16'd100});
        press_start();
        ride_out(1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // echo at the last count before the limit
    task automatic test_longest_flight();
        program_timing(cfg_t'{16'd0, 8'd1, 4'd1, 16'd0, 16'd250});
        press_start();
        while (seq_phase != SEQ_IDLE && flight_ticks < 249)
            send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // random settings with start and echo patterns shaped by the sequencer state
    task automatic test_random();
        cfg_t        s;
        int unsigned mark;
        logic        st;
        logic        ec;
        mark = 0;
        repeat (6)
        begin
            s.debounce_ticks    = CFG_W'($urandom_range(6));
            s.half_period_ticks = HALF_W'($urandom_range(3));
            s.burst_pulses      = PULSE_W'($urandom_range(15));
            s.blanking_ticks    = CFG_W'($urandom_range(12));
            case ($urandom_range(3))
                0: s.count_limit = CFG_W'($urandom_range(20));
                1: s.count_limit = CFG_W'($urandom_range(150, 40));
                2: s.count_limit = CFG_W'($urandom_range(900, 150));
                default: s.count_limit = CFG_W'($urandom());
            endcase
            if ($urandom_range(7) == 0)
                s.debounce_ticks = CFG_W'($urandom());
            if ($urandom_range(7) == 0)
                s.half_period_ticks = HALF_W'($urandom());
            if ($urandom_range(7) == 0)
                s.blanking_ticks = CFG_W'($urandom());
            program_timing(s);
            repeat (120)
            begin
                if (seq_phase == SEQ_IDLE || seq_phase == SEQ_DEBOUNCE)
                    mark = $urandom_range(100);
                st = 1'($urandom_range(1));
                ec = 1'($urandom_range(1));
                if ($urandom_range(99) >= 10)
                begin
                    case (seq_phase)
                        SEQ_IDLE:     st = ($urandom_range(99) >= 30);
                        SEQ_DEBOUNCE: st = ($urandom_range(99) >= 85);
                        SEQ_LISTEN:   ec = (flight_ticks < mark);
                        default:      ;
                    endcase
                end
                send_tick(st, ec);
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zero_settings();
        test_debounce_release();
        test_timeouts();
        test_slow_corners();
        test_longest_flight();
        test_random();
        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/urc_pkg.sv
hw/rtl/urc_in_stage.sv
hw/rtl/urc_dist_acc.sv
hw/rtl/urc_core.sv
hw/rtl/urc_out_queue.sv
hw/rtl/ultrasonic_range_controller.sv
sim/tb_ultrasonic_range_controller.sv
